### sv/pse_pkg.sv
// Package: shared types, token codes and arithmetic helpers for the postfix evaluator.
`timescale 1ns / 1ps
package pse_pkg;

  localparam logic [7:0] TOK_END  = 8'h00;
  localparam logic [7:0] TOK_ZERO = 8'h30;
  localparam logic [7:0] TOK_NINE = 8'h39;
  localparam logic [7:0] TOK_ADD  = 8'h2B;
  localparam logic [7:0] TOK_SUB  = 8'h2D;
  localparam logic [7:0] TOK_MUL  = 8'h2A;
  localparam logic [7:0] TOK_DIV  = 8'h2F;
  localparam logic [7:0] TOK_POW  = 8'h24;

  localparam logic [63:0] Q_ONE    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_NEGMAX = 64'h8000_0000_0000_0001;
  // exp2 input range: [-32.0, 31.0)
  localparam logic signed [63:0] EXP_HI = 64'sh0000_001F_0000_0000;
  localparam logic signed [63:0] EXP_LO = 64'shFFFF_FFE0_0000_0000;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam int MUL_STEPS = 4;
  localparam int LOG_BITS  = 32;
  localparam int DIV_STEPS = 128;
  localparam int EXP_TERMS = 12;

  typedef enum logic [2:0] {
    ST_OK,
    ST_INVALID,
    ST_UNDERFLOW,
    ST_OVERFLOW,
    ST_DIVZERO,
    ST_DOMAIN
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } alu_op_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DEC,
    C_END,
    C_RD_R,
    C_RD_L,
    C_ALU,
    C_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_LNRM,
    A_LSQM,
    A_LSQA,
    A_EXPT,
    A_EXPA,
    A_TRM1,
    A_TRM2,
    A_TRM3,
    A_TRM4,
    A_EXPF,
    A_DONE
  } alu_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic    done;
    status_t status;
  } alu_rsp_t;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] sat_mag(input logic neg, input logic [63:0] m,
                                          input logic ovf);
    if (neg) begin
      sat_mag = (ovf || m[63]) ? Q_MIN : (64'd0 - m);
    end else begin
      sat_mag = (ovf || m[63]) ? Q_MAX : m;
    end
  endfunction

  // floor(2^32 / k) for the exp series terms
  function automatic logic [32:0] rcp(input logic [3:0] k);
    case (k)
      4'd1:    rcp = 33'd4294967296;
      4'd2:    rcp = 33'd2147483648;
      4'd3:    rcp = 33'd1431655765;
      4'd4:    rcp = 33'd1073741824;
      4'd5:    rcp = 33'd858993459;
      4'd6:    rcp = 33'd715827882;
      4'd7:    rcp = 33'd613566756;
      4'd8:    rcp = 33'd536870912;
      4'd9:    rcp = 33'd477218588;
      4'd10:   rcp = 33'd429496729;
      4'd11:   rcp = 33'd390451572;
      4'd12:   rcp = 33'd357913941;
      default: rcp = 33'd0;
    endcase
  endfunction

endpackage

### sv/pse_if.sv
// Interfaces: token input channel and result output channel.
`timescale 1ns / 1ps
interface pse_token_if;
  logic       valid;
  logic       ready;
  logic [7:0] token;
  modport source (output valid, output token, input ready);
  modport sink (input valid, input token, output ready);
endinterface

interface pse_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [2:0]         status;
  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

### sv/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data <= mem_r[raddr];
  end

endmodule

### sv/pse_alu.sv
// Multi-cycle Q32.32 arithmetic unit: add, sub, mul, div, log/exp power.
`timescale 1ns / 1ps
module pse_alu import pse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  alu_req_t    req,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output alu_rsp_t    rsp,
  output logic [63:0] result
);

  alu_state_t  state_r, state_nxt;
  alu_op_t     op_r;
  logic [63:0] b_r;
  logic        neg_r, flip_r, ovf_r;
  logic [63:0] ma_r, mb_r;
  logic [127:0] acc_r;
  logic [6:0]  cnt_r;
  logic [127:0] dvd_r;
  logic [64:0] rem_r;
  logic [63:0] q_r;
  logic [63:0] nrm_r;
  logic [5:0]  p_r;
  logic [31:0] m_r, frac_r;
  logic [31:0] t_r, x_r;
  logic [32:0] term_r;
  logic [33:0] s_r;
  logic [3:0]  k_r;
  logic signed [6:0] n_r;
  logic [63:0] res_r;
  status_t     st_r;
  logic [65:0] prod_r;

  logic [32:0]  mul_x, mul_y;
  logic [127:0] acc_add, acc_sum;
  logic [63:0]  mres;
  logic         y_hi, y_lo;
  logic [63:0]  uy;
  logic [64:0]  add_s, sub_s;
  logic [63:0]  add_sat, sub_sat;
  logic [64:0]  remx, rem_new;
  logic [63:0]  q_new;
  logic         ovf_new;
  logic [32:0]  sq_v;
  logic [31:0]  frac_new, m_new;
  logic [63:0]  lg;
  logic [31:0]  corr_r;
  logic [32:0]  tnew;
  logic [63:0]  shifted;
  logic [6:0]   nneg;
  logic [63:0]  init_res;
  status_t      init_st;

  always_comb begin
    // accumulate the partial product registered in the previous step
    acc_add = '0;
    if (cnt_r != '0) begin
      unique case (cnt_r[1:0])
        2'd1:    acc_add = 128'(prod_r[63:0]);
        2'd0:    acc_add = 128'(prod_r[63:0]) << 64;
        default: acc_add = 128'(prod_r[63:0]) << 32;
      endcase
    end
    acc_sum = acc_r + acc_add;
    mres    = sat_mag(neg_r, acc_sum[95:32], |acc_sum[127:96]);
    y_hi    = $signed(mres) >= EXP_HI;
    y_lo    = $signed(mres) < EXP_LO;
    uy      = mres - EXP_LO;

    add_s   = {opa[63], opa} + {opb[63], opb};
    sub_s   = {opa[63], opa} - {opb[63], opb};
    add_sat = (add_s[64] != add_s[63]) ? (add_s[64] ? Q_MIN : Q_MAX) : add_s[63:0];
    sub_sat = (sub_s[64] != sub_s[63]) ? (sub_s[64] ? Q_MIN : Q_MAX) : sub_s[63:0];

    // result and status known at the start of an operation
    init_res = '0;
    init_st  = ST_OK;
    case (req.op)
      OP_ADD: init_res = add_sat;
      OP_SUB: init_res = sub_sat;
      OP_DIV: if (opb == '0) init_st = ST_DIVZERO;
      OP_POW: begin
        if (opa == '0) begin
          if (opb[63]) init_st = ST_DOMAIN;
          else init_res = (opb == '0) ? Q_ONE : '0;
        end else if (opa[63] && opb[31:0] != '0) begin
          init_st = ST_DOMAIN;
        end
      end
      default: ;
    endcase

    remx    = {rem_r[63:0], dvd_r[127]};
    ovf_new = ovf_r | q_r[63];
    if (remx >= {1'b0, mb_r}) begin
      rem_new = remx - {1'b0, mb_r};
      q_new   = {q_r[62:0], 1'b1};
    end else begin
      rem_new = remx;
      q_new   = {q_r[62:0], 1'b0};
    end

    // one log2 fraction bit per squaring
    sq_v     = prod_r[63:31];
    frac_new = {frac_r[30:0], sq_v[32]};
    m_new    = sq_v[32] ? sq_v[32:1] : sq_v[31:0];
    lg       = {32'({26'd0, p_r}) - 32'd32, frac_new};

    corr_r = x_r - prod_r[31:0];
    tnew   = term_r + 33'(corr_r >= {28'd0, k_r});

    nneg = 7'd0 - n_r;
    if (!n_r[6]) begin
      shifted = {30'd0, s_r} << n_r[5:0];
    end else begin
      shifted = {30'd0, s_r} >> nneg[5:0];
    end

    mul_x     = '0;
    mul_y     = '0;
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_MUL:  state_nxt = A_MUL;
            OP_DIV:  state_nxt = (opb == '0) ? A_DONE : A_DIV;
            OP_POW:  state_nxt = ((opa == '0) || (opa[63] && opb[31:0] != '0)) ?
                                 A_DONE : A_LNRM;
            default: state_nxt = A_DONE;
          endcase
        end
      end
      A_LNRM: if (nrm_r[63]) state_nxt = A_LSQM;
      A_LSQM: begin
        mul_x     = {1'b0, m_r};
        mul_y     = {1'b0, m_r};
        state_nxt = A_LSQA;
      end
      A_LSQA: state_nxt = (cnt_r == 7'(LOG_BITS - 1)) ? A_MUL : A_LSQM;
      A_MUL: begin
        mul_x = {1'b0, cnt_r[1] ? ma_r[63:32] : ma_r[31:0]};
        mul_y = {1'b0, cnt_r[0] ? mb_r[63:32] : mb_r[31:0]};
        if (cnt_r == 7'(MUL_STEPS)) begin
          if (op_r == OP_MUL || y_hi || y_lo) state_nxt = A_DONE;
          else state_nxt = A_EXPT;
        end
      end
      A_EXPT: begin
        mul_x     = {1'b0, x_r};
        mul_y     = {1'b0, LN2_Q32};
        state_nxt = A_EXPA;
      end
      A_EXPA: state_nxt = A_TRM1;
      A_TRM1: begin
        mul_x     = term_r;
        mul_y     = {1'b0, t_r};
        state_nxt = A_TRM2;
      end
      A_TRM2: begin
        mul_x     = {1'b0, prod_r[63:32]};
        mul_y     = rcp(k_r);
        state_nxt = A_TRM3;
      end
      A_TRM3: begin
        mul_x     = {1'b0, prod_r[63:32]};
        mul_y     = {29'd0, k_r};
        state_nxt = A_TRM4;
      end
      A_TRM4: state_nxt = (k_r == 4'(EXP_TERMS)) ? A_EXPF : A_TRM1;
      A_EXPF: state_nxt = A_DONE;
      A_DIV:  if (cnt_r == 7'(DIV_STEPS - 1)) state_nxt = A_DONE;
      A_DONE: state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase

    rsp.done   = state_r == A_DONE;
    rsp.status = st_r;
    result     = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= {33'd0, mul_x} * {33'd0, mul_y};
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          op_r   <= req.op;
          b_r    <= opb;
          res_r  <= init_res;
          st_r   <= init_st;
          acc_r  <= '0;
          cnt_r  <= '0;
          neg_r  <= opa[63] ^ opb[63];
          flip_r <= opa[63] & opb[32];
          ma_r   <= mag64(opa);
          mb_r   <= mag64(opb);
          dvd_r  <= {32'd0, mag64(opa), 32'd0};
          rem_r  <= '0;
          q_r    <= '0;
          ovf_r  <= 1'b0;
          nrm_r  <= mag64(opa);
          p_r    <= 6'd63;
        end
      end
      A_LNRM: begin
        if (!nrm_r[63]) begin
          nrm_r <= nrm_r << 1;
          p_r   <= p_r - 6'd1;
        end else begin
          m_r    <= nrm_r[63:32];
          frac_r <= '0;
          cnt_r  <= '0;
        end
      end
      A_LSQA: begin
        frac_r <= frac_new;
        m_r    <= m_new;
        cnt_r  <= (cnt_r == 7'(LOG_BITS - 1)) ? 7'd0 : cnt_r + 7'd1;
        if (cnt_r == 7'(LOG_BITS - 1)) begin
          // exponent times log2(|base|)
          ma_r  <= mag64(b_r);
          mb_r  <= mag64(lg);
          neg_r <= b_r[63] ^ lg[63];
          acc_r <= '0;
        end
      end
      A_MUL: begin
        acc_r <= acc_sum;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(MUL_STEPS)) begin
          x_r   <= uy[31:0];
          n_r   <= $signed({1'b0, uy[37:32]}) - 7'sd32;
          if (op_r == OP_MUL) res_r <= mres;
          else if (y_hi) res_r <= flip_r ? Q_NEGMAX : Q_MAX;
          else res_r <= '0;
        end
      end
      A_EXPA: begin
        t_r    <= prod_r[63:32];
        term_r <= 33'h1_0000_0000;
        s_r    <= 34'h1_0000_0000;
        k_r    <= 4'd1;
      end
      A_TRM2: x_r <= prod_r[63:32];
      A_TRM3: term_r <= {1'b0, prod_r[63:32]};
      A_TRM4: begin
        term_r <= tnew;
        s_r    <= s_r + {1'b0, tnew};
        k_r    <= k_r + 4'd1;
      end
      A_EXPF: res_r <= flip_r ? (64'd0 - shifted) : shifted;
      A_DIV: begin
        dvd_r <= dvd_r << 1;
        rem_r <= rem_new;
        q_r   <= q_new;
        ovf_r <= ovf_new;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) res_r <= sat_mag(neg_r, q_new, ovf_new);
      end
      default: ;
    endcase
  end

endmodule

### sv/postfix_stack_evaluator.sv
// Postfix evaluator top level: token decode, operand stack in RAM, result output.
//
// in_chan carries one expression character per transaction; a zero byte ends
// the expression. out_chan carries value (signed Q32.32) and status per result;
// only a terminator or an error produces a result.
// Work per token, from acceptance to ready again: a digit is pushed; a
//   terminator reads the top of stack, then waits for the output; an operator
//   runs in the arithmetic unit, / with one quotient bit per cycle in the
//   restoring divider, $ with a leading-one shift of up to 63 places, then 32
//   squarings through the shared multiplier and 12 series terms.
// The next token is taken only after the current one is finished; an operator
// reads its two operands from the stack RAM one per cycle.
// The output register holds a result until taken; a new token is accepted
// while it waits, and the block stalls only when a second result is due.
// Reset clears the stack pointer and the error flag; the stack RAM itself
// needs no clearing since only entries below the pointer are read.
// After an error on any token but the terminator, tokens are dropped up to and including the next terminator.
`timescale 1ns / 1ps
module postfix_stack_evaluator import pse_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  pse_token_if.sink           in_chan,
  pse_result_if.source        out_chan
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  ctl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  top_r, top_nxt;
  logic              err_r, err_nxt;
  logic [7:0]        tok_r;
  logic [63:0]       right_r, right_nxt;
  logic [63:0]       pv_r, pv_nxt;
  status_t           ps_r, ps_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_value_r, out_value_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [63:0]       wdata, rd_data;
  logic [CNT_W-1:0]  top_m1, top_m2;
  logic              is_digit, is_op;
  alu_op_t           dec_op;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [63:0]       alu_res;

  pse_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rd_data(rd_data)
  );

  pse_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (rd_data),
    .opb   (right_r),
    .rsp   (alu_rsp),
    .result(alu_res)
  );

  assign in_chan.ready   = state_r == C_IDLE;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = out_value_r;
  assign out_chan.status = out_status_r;

  assign top_m1   = top_r - CNT_W'(1);
  assign top_m2   = top_r - CNT_W'(2);
  assign is_digit = (tok_r >= TOK_ZERO) && (tok_r <= TOK_NINE);

  always_comb begin
    is_op  = 1'b1;
    dec_op = OP_ADD;
    unique case (tok_r)
      TOK_ADD: dec_op = OP_ADD;
      TOK_SUB: dec_op = OP_SUB;
      TOK_MUL: dec_op = OP_MUL;
      TOK_DIV: dec_op = OP_DIV;
      TOK_POW: dec_op = OP_POW;
      default: is_op = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    err_nxt        = err_r;
    right_nxt      = right_r;
    pv_nxt         = pv_r;
    ps_nxt         = ps_r;
    out_valid_nxt  = out_valid_r & ~out_chan.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    we             = 1'b0;
    waddr          = top_r[ADDR_W-1:0];
    wdata          = {28'd0, tok_r[3:0], 32'd0};
    raddr          = (state_r == C_RD_R) ? top_m2[ADDR_W-1:0] : top_m1[ADDR_W-1:0];
    alu_req.start  = 1'b0;
    alu_req.op     = dec_op;

    unique case (state_r)
      C_IDLE: if (in_chan.valid) state_nxt = C_DEC;
      C_DEC: begin
        state_nxt = C_IDLE;
        if (err_r) begin
          if (tok_r == TOK_END) begin
            err_nxt = 1'b0;
            top_nxt = '0;
          end
        end else if (tok_r == TOK_END) begin
          if (top_r == '0) begin
            pv_nxt    = '0;
            ps_nxt    = ST_UNDERFLOW;
            state_nxt = C_EMIT;
          end else begin
            state_nxt = C_END;
          end
        end else if (is_digit) begin
          if (top_r >= CNT_W'(STACK_DEPTH)) begin
            pv_nxt    = '0;
            ps_nxt    = ST_OVERFLOW;
            top_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = C_EMIT;
          end else begin
            we      = 1'b1;
            top_nxt = top_r + CNT_W'(1);
          end
        end else if (is_op && top_r >= CNT_W'(2)) begin
          state_nxt = C_RD_R;
        end else begin
          pv_nxt    = '0;
          ps_nxt    = is_op ? ST_UNDERFLOW : ST_INVALID;
          top_nxt   = '0;
          err_nxt   = 1'b1;
          state_nxt = C_EMIT;
        end
      end
      C_END: begin
        pv_nxt    = rd_data;
        ps_nxt    = ST_OK;
        top_nxt   = '0;
        state_nxt = C_EMIT;
      end
      C_RD_R: begin
        right_nxt = rd_data;
        state_nxt = C_RD_L;
      end
      C_RD_L: begin
        alu_req.start = 1'b1;
        top_nxt       = top_m2;
        state_nxt     = C_ALU;
      end
      C_ALU: begin
        if (alu_rsp.done) begin
          if (alu_rsp.status == ST_OK) begin
            we        = 1'b1;
            wdata     = alu_res;
            top_nxt   = top_r + CNT_W'(1);
            state_nxt = C_IDLE;
          end else begin
            pv_nxt    = '0;
            ps_nxt    = alu_rsp.status;
            top_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = C_EMIT;
          end
        end
      end
      C_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = pv_r;
          out_status_nxt = ps_r;
          state_nxt      = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      top_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      tok_r <= in_chan.token;
    end
    right_r      <= right_nxt;
    pv_r         <= pv_nxt;
    ps_r         <= ps_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CNT_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> top_r == '0)
    else $error("stack not cleared while discarding");

  a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == C_ALU)
    else $error("arithmetic unit finished with no operation pending");

  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_EMIT && (!out_valid_r || out_chan.ready)) |=>
      (out_valid_r && state_r == C_IDLE))
    else $error("result not loaded into output register");

endmodule

### bench/postfix_stack_evaluator_tb.sv
// Testbench for the postfix evaluator: directed table, random expressions, scoreboard.
`timescale 1ns / 1ps
module postfix_stack_evaluator_tb import pse_pkg::*;;

  localparam int DEPTH      = 128;
  localparam int RAND_ITEMS = 1400;
  localparam int QUIET_TAIL = 150;
  localparam int WDOG_LIMIT = 5000;
  localparam int TAIL_WAIT  = 300;

  typedef struct {
    logic [63:0] value;
    status_t     status;
  } result_t;

  typedef struct {
    logic [7:0]  tok;
    bit          typed;
    logic [63:0] value;
    status_t     status;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  pse_token_if  tok_if ();
  pse_result_if res_if ();

  postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (tok_if),
    .out_chan (res_if)
  );

  always #6 clk = ~clk;

  result_t     pending_results[$];
  row_t        dir_rows[$];
  logic [63:0] model_stack[DEPTH];
  int          model_top;
  bit          model_err;
  int          fail_count;
  bit          quiet;
  int          idle_cycles;
  int          ready_hold;
  int          items_sent;

  // ---------------- fixed-point arithmetic ----------------
  function automatic logic [63:0] mag(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic [63:0] saturate(bit neg, logic [63:0] m, bit ovf);
    if (neg) return (ovf || m[63]) ? Q_MIN : 64'd0 - m;
    return (ovf || m[63]) ? Q_MAX : m;
  endfunction

  function automatic logic [63:0] fx_add(logic [63:0] a, logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({1'b0, Q_MAX})) return Q_MAX;
    if (s < $signed({1'b1, Q_MIN})) return Q_MIN;
    return s[63:0];
  endfunction

  function automatic logic [63:0] fx_sub(logic [63:0] a, logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) - $signed({b[63], b});
    if (s > $signed({1'b0, Q_MAX})) return Q_MAX;
    if (s < $signed({1'b1, Q_MIN})) return Q_MIN;
    return s[63:0];
  endfunction

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    return saturate(a[63] ^ b[63], p[95:32], |p[127:96]);
  endfunction

  function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    q = {32'd0, mag(a), 32'd0} / {64'd0, mag(b)};
    return saturate(a[63] ^ b[63], q[63:0], |q[127:64]);
  endfunction

  function automatic logic [63:0] fx_log2(logic [63:0] r);
    int p;
    logic [63:0] m, frac;
    p = 63;
    frac = 0;
    while (p > 0 && !r[p]) p--;
    m = (p >= 31) ? r >> (p - 31) : r << (31 - p);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= Q_ONE) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(longint'(p - 32)) << 32) + frac;
  endfunction

  function automatic logic [63:0] fx_exp2(logic signed [63:0] y);
    logic [63:0] uy, f, t, s, term;
    int n;
    if (y >= EXP_HI) return Q_MAX;
    if (y < EXP_LO) return 64'd0;
    uy = y - EXP_LO;
    n = int'(uy[63:32]) - 32;
    f = {32'd0, uy[31:0]};
    t = (f * {32'd0, LN2_Q32}) >> 32;
    s = Q_ONE;
    term = Q_ONE;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * t) >> 32) / k;
      s = s + term;
    end
    return (n >= 0) ? s << n : s >> (-n);
  endfunction

  function automatic status_t fx_pow(logic [63:0] base, logic [63:0] ex,
                                     output logic [63:0] res);
    logic [63:0] r;
    bit flip;
    res = 0;
    flip = 0;
    if (base == 0) begin
      if (ex[63]) return ST_DOMAIN;
      res = (ex == 0) ? Q_ONE : 64'd0;
      return ST_OK;
    end
    if (base[63]) begin
      if (ex[31:0] != 0) return ST_DOMAIN;
      flip = ex[32];
    end
    r = fx_exp2(fx_mul(ex, fx_log2(mag(base))));
    res = flip ? 64'd0 - r : r;
    return ST_OK;
  endfunction

  // ---------------- evaluator prediction ----------------
  function automatic bit abort_expr(status_t st, bit at_end, output result_t r);
    model_top = 0;
    model_err = !at_end;
    r.value = 0;
    r.status = st;
    return 1;
  endfunction

  function automatic bit eval_token(logic [7:0] tok, output result_t r);
    logic [63:0] lhs, rhs, res;
    status_t st;
    r.value = 0;
    r.status = ST_OK;
    res = 0;
    st = ST_OK;
    if (model_err) begin
      if (tok == TOK_END) begin
        model_err = 0;
        model_top = 0;
      end
      return 0;
    end
    if (tok == TOK_END) begin
      if (model_top == 0) return abort_expr(ST_UNDERFLOW, 1, r);
      r.value = model_stack[model_top - 1];
      model_top = 0;
      return 1;
    end
    if (tok >= TOK_ZERO && tok <= TOK_NINE) begin
      if (model_top >= DEPTH) return abort_expr(ST_OVERFLOW, 0, r);
      model_stack[model_top] = {24'd0, tok - TOK_ZERO, 32'd0};
      model_top++;
      return 0;
    end
    if (!(tok inside {TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV, TOK_POW}))
      return abort_expr(ST_INVALID, 0, r);
    if (model_top < 2) return abort_expr(ST_UNDERFLOW, 0, r);
    rhs = model_stack[model_top - 1];
    lhs = model_stack[model_top - 2];
    model_top -= 2;
    case (tok)
      TOK_ADD: res = fx_add(lhs, rhs);
      TOK_SUB: res = fx_sub(lhs, rhs);
      TOK_MUL: res = fx_mul(lhs, rhs);
      TOK_DIV: begin
        if (rhs == 0) st = ST_DIVZERO;
        else res = fx_div(lhs, rhs);
      end
      default: st = fx_pow(lhs, rhs, res);
    endcase
    if (st != ST_OK) return abort_expr(st, 0, r);
    model_stack[model_top] = res;
    model_top++;
    return 0;
  endfunction

  // ---------------- scoreboard ----------------
  row_t cur_row;
  bit   cur_from_table;

  always @(posedge clk) begin
    result_t r;
    if (rst_n && tok_if.valid && tok_if.ready) begin
      if (eval_token(tok_if.token, r)) begin
        if (cur_from_table && cur_row.typed) begin
          r.value = cur_row.value;
          r.status = cur_row.status;
        end
        pending_results.push_back(r);
      end
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 res_if.value, res_if.status);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (res_if.value !== e.value) begin
          $display("%0t: value mismatch expected=%h actual=%h", $time,
                   e.value, res_if.value);
          fail_count++;
        end
        if (res_if.status !== e.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                   e.status, res_if.status);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      res_if.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!quiet && $urandom_range(7) == 0) begin
      res_if.ready <= 1'b0;
      ready_hold <= $urandom_range(11, 1) - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((tok_if.valid && tok_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: watchdog timeout", $time);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_token(logic [7:0] tok);
    if (!quiet && $urandom_range(3) == 0) begin
      tok_if.valid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
    tok_if.token <= tok;
    tok_if.valid <= 1'b1;
    do @(posedge clk); while (!(tok_if.valid && tok_if.ready));
    items_sent++;
  endtask

  task automatic add_row(logic [7:0] tok, bit typed = 0, logic [63:0] value = 0,
                         status_t status = ST_OK);
    row_t rw;
    rw.tok = tok;
    rw.typed = typed;
    rw.value = value;
    rw.status = status;
    dir_rows.push_back(rw);
  endtask

  function automatic logic [7:0] rand_digit();
    return TOK_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(4))
      0: return TOK_ADD;
      1: return TOK_SUB;
      2: return TOK_MUL;
      3: return TOK_DIV;
      default: return TOK_POW;
    endcase
  endfunction

  // postfix with random content, possibly leaving unused operands, optionally broken
  task automatic send_expression(bit broken);
    int depth, operands;
    operands = $urandom_range(6, 1);
    depth = 0;
    while (operands > 0 || depth > 1) begin
      if (broken && $urandom_range(5) == 0) begin
        send_token($urandom_range(1) ? rand_op() : 8'($urandom_range(255)));
      end
      if (operands > 0 && (depth < 2 || $urandom_range(1))) begin
        send_token(rand_digit());
        depth++;
        operands--;
      end else if (depth >= 2 && $urandom_range(7) != 0) begin
        send_token(rand_op());
        depth--;
      end else begin
        break;
      end
    end
    send_token(TOK_END);
  endtask

  task automatic send_overflow_run();
    repeat (DEPTH + 1) send_token(rand_digit());
    repeat ($urandom_range(3)) send_token(rand_op());
    send_token(TOK_END);
  endtask

  initial begin
    int sel;
    rst_n = 1'b0;
    tok_if.valid = 1'b0;
    tok_if.token = TOK_END;
    res_if.ready = 1'b0;
    fail_count = 0;
    quiet = 0;
    idle_cycles = 0;
    items_sent = 0;
    model_top = 0;
    model_err = 0;
    cur_from_table = 0;
    foreach (model_stack[i]) model_stack[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // terminator on an empty stack
    add_row(TOK_END, 1, 0, ST_UNDERFLOW);
    add_row(TOK_NINE);
    add_row(TOK_NINE);
    add_row(TOK_MUL);
    add_row(TOK_END, 1, 64'h0000_0051_0000_0000, ST_OK);
    add_row(TOK_ZERO + 8'd8);
    add_row(TOK_ZERO);
    add_row(TOK_DIV, 1, 0, ST_DIVZERO);
    add_row(TOK_END);
    add_row(8'hFF, 1, 0, ST_INVALID);
    add_row(TOK_END);
    add_row(TOK_ZERO + 8'd3);
    add_row(TOK_ADD, 1, 0, ST_UNDERFLOW);
    add_row(TOK_END);
    // negative base, fractional exponent
    add_row(TOK_ZERO);
    add_row(TOK_ZERO + 8'd1);
    add_row(TOK_SUB);
    add_row(TOK_ZERO + 8'd1);
    add_row(TOK_ZERO + 8'd2);
    add_row(TOK_DIV);
    add_row(TOK_POW, 1, 0, ST_DOMAIN);
    add_row(TOK_END);
    // zero base, negative exponent
    add_row(TOK_ZERO);
    add_row(TOK_ZERO);
    add_row(TOK_ZERO + 8'd1);
    add_row(TOK_SUB);
    add_row(TOK_POW, 1, 0, ST_DOMAIN);
    add_row(TOK_END);

    // row state changes after the accepting edge has been scored
    cur_from_table <= 1;
    foreach (dir_rows[i]) begin
      cur_row <= dir_rows[i];
      send_token(dir_rows[i].tok);
    end
    tok_if.valid <= 1'b0;
    @(posedge clk);
    cur_from_table <= 0;

    // hold off until the pipeline has drained
    while (pending_results.size() != 0) @(posedge clk);

    send_overflow_run();
    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      if (items_sent > RAND_ITEMS - QUIET_TAIL) quiet = 1;
      sel = $urandom_range(99);
      if (sel < 75) send_expression(0);
      else if (sel < 88) send_expression(1);
      else if (sel < 99) send_token(8'($urandom_range(255)));
      else send_overflow_run();
    end
    tok_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/pse_pkg.sv
sv/pse_if.sv
sv/pse_ram.sv
sv/pse_alu.sv
sv/postfix_stack_evaluator.sv
bench/postfix_stack_evaluator_tb.sv
